// ===== rtl/core/hlw_pkg.sv =====
`default_nettype none

package hlw_pkg;

    localparam int unsigned CFG_ADDR_W = 3;
    localparam int unsigned CFG_DATA_W = 32;

    localparam logic [7:0]  MISS_THRESHOLD_RST = 8'd3;
    localparam logic [19:0] MAX_BACKOFF_RST    = 20'd30000;
    localparam logic [19:0] BACKOFF_START_MS   = 20'd1000;
    localparam logic [62:0] RTT_LIMIT_NS       = 63'd2000000000;
    localparam logic [7:0]  MISS_SATURATE      = 8'd255;

    typedef enum logic [0:0] {
        REG_MISS_THRESHOLD = 1'b0,
        REG_MAX_BACKOFF    = 1'b1
    } t_reg_idx;

    typedef enum logic [1:0] {
        CMD_START = 2'd0,
        CMD_PONG  = 2'd1,
        CMD_END   = 2'd2
    } t_cmd;

    typedef enum logic [2:0] {
        ST_STARTED      = 3'd0,
        ST_PONG_KEPT    = 3'd1,
        ST_PONG_DROPPED = 3'd2,
        ST_ANSWERED     = 3'd3,
        ST_MISSED       = 3'd4,
        ST_RESET_OK     = 3'd5,
        ST_RECONNECT_OK = 3'd6,
        ST_FAILED       = 3'd7
    } t_status;

    typedef struct packed {
        logic [1:0]  command;
        logic [62:0] ping_stamp;
        logic [62:0] local_time;
        logic        reset_ok;
        logic        reconnect_ok;
    } t_in_beat;

    typedef struct packed {
        logic [2:0]  status;
        logic        link_down;
        logic [7:0]  missed_count;
        logic [31:0] reconnect_count;
        logic [19:0] wait_ms;
        logic [30:0] last_rtt;
        logic [30:0] min_rtt;
    } t_out_beat;

    typedef struct packed {
        logic [7:0]  miss_threshold;
        logic [19:0] max_backoff_ms;
    } t_cfg;

endpackage

`default_nettype wire

// ===== rtl/core/hlw_cfg_regs.sv =====
`default_nettype none

module hlw_cfg_regs import hlw_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready,
    output t_cfg                       o_cfg
);

    logic [7:0]  r_miss_threshold;
    logic [19:0] r_max_backoff_ms;
    logic        wr_en;
    t_reg_idx    reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite;
    assign reg_idx = t_reg_idx'(paddr[2]);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_miss_threshold <= MISS_THRESHOLD_RST;
            r_max_backoff_ms <= MAX_BACKOFF_RST;
        end else if (wr_en) begin
            case (reg_idx)
                REG_MISS_THRESHOLD: r_miss_threshold <= pwdata[7:0];
                REG_MAX_BACKOFF:    r_max_backoff_ms <= pwdata[19:0];
                default:            r_miss_threshold <= r_miss_threshold;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_MISS_THRESHOLD: prdata = {24'd0, r_miss_threshold};
            REG_MAX_BACKOFF:    prdata = {12'd0, r_max_backoff_ms};
            default:            prdata = '0;
        endcase
    end

    assign o_cfg.miss_threshold = r_miss_threshold;
    assign o_cfg.max_backoff_ms = r_max_backoff_ms;

endmodule

`default_nettype wire

// ===== rtl/core/hlw_core.sv =====
`default_nettype none

module hlw_core import hlw_pkg::*; (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_fire,
    input  wire t_in_beat  i_beat,
    input  wire t_cfg      i_cfg,
    output t_out_beat      o_beat
);

    logic        r_pong_seen;
    logic [7:0]  r_miss_count;
    logic        r_down_flag;
    logic [19:0] r_backoff_ms;
    logic [31:0] r_recovery_count;
    logic [30:0] r_last_rtt;
    logic [30:0] r_min_rtt;

    logic        n_pong_seen;
    logic [7:0]  n_miss_count;
    logic        n_down_flag;
    logic [19:0] n_backoff_ms;
    logic [31:0] n_recovery_count;
    logic [30:0] n_last_rtt;
    logic [30:0] n_min_rtt;

    logic [63:0] rtt_diff;
    logic        rtt_drop;
    logic [30:0] rtt;
    logic [7:0]  miss_inc;
    logic [20:0] doubled;
    logic [19:0] backoff_next;
    t_status     status;
    logic [19:0] wait_ms;

    // round trip with borrow in the top bit
    assign rtt_diff = {1'b0, i_beat.local_time} - {1'b0, i_beat.ping_stamp};
    assign rtt_drop = rtt_diff[63] || (rtt_diff[62:0] > RTT_LIMIT_NS);
    assign rtt      = rtt_diff[30:0];
    assign miss_inc = (r_miss_count == MISS_SATURATE) ? MISS_SATURATE : r_miss_count + 8'd1;
    assign doubled  = {r_backoff_ms, 1'b0};
    assign backoff_next = (doubled < {1'b0, i_cfg.max_backoff_ms})
                          ? doubled[19:0] : i_cfg.max_backoff_ms;

    always_comb begin
        n_pong_seen      = r_pong_seen;
        n_miss_count     = r_miss_count;
        n_down_flag      = r_down_flag;
        n_backoff_ms     = r_backoff_ms;
        n_recovery_count = r_recovery_count;
        n_last_rtt       = r_last_rtt;
        n_min_rtt        = r_min_rtt;
        status           = ST_STARTED;
        wait_ms          = '0;
        case (t_cmd'(i_beat.command))
            CMD_START: begin
                n_pong_seen = 1'b0;
                status      = ST_STARTED;
            end
            CMD_PONG: begin
                if (rtt_drop) begin
                    status = ST_PONG_DROPPED;
                end else begin
                    n_last_rtt  = rtt;
                    if ((r_min_rtt == '0) || (rtt < r_min_rtt)) begin
                        n_min_rtt = rtt;
                    end
                    n_pong_seen = 1'b1;
                    status      = ST_PONG_KEPT;
                end
            end
            CMD_END: begin
                if (r_pong_seen) begin
                    n_miss_count = '0;
                    n_backoff_ms = BACKOFF_START_MS;
                    n_down_flag  = 1'b0;
                    status       = ST_ANSWERED;
                end else if (miss_inc < i_cfg.miss_threshold) begin
                    n_miss_count = miss_inc;
                    status       = ST_MISSED;
                end else begin
                    n_recovery_count = r_recovery_count + 32'd1;
                    n_miss_count     = '0;
                    if (i_beat.reset_ok || i_beat.reconnect_ok) begin
                        n_down_flag  = 1'b0;
                        n_backoff_ms = BACKOFF_START_MS;
                        status       = i_beat.reset_ok ? ST_RESET_OK : ST_RECONNECT_OK;
                    end else begin
                        n_down_flag  = 1'b1;
                        wait_ms      = r_backoff_ms;
                        n_backoff_ms = backoff_next;
                        status       = ST_FAILED;
                    end
                end
            end
            default: begin
                status = ST_STARTED;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pong_seen      <= 1'b0;
            r_miss_count     <= '0;
            r_down_flag      <= 1'b0;
            r_backoff_ms     <= BACKOFF_START_MS;
            r_recovery_count <= '0;
            r_last_rtt       <= '0;
            r_min_rtt        <= '0;
        end else if (i_fire) begin
            r_pong_seen      <= n_pong_seen;
            r_miss_count     <= n_miss_count;
            r_down_flag      <= n_down_flag;
            r_backoff_ms     <= n_backoff_ms;
            r_recovery_count <= n_recovery_count;
            r_last_rtt       <= n_last_rtt;
            r_min_rtt        <= n_min_rtt;
        end
    end

    assign o_beat.status          = status;
    assign o_beat.link_down       = n_down_flag;
    assign o_beat.missed_count    = n_miss_count;
    assign o_beat.reconnect_count = n_recovery_count;
    assign o_beat.wait_ms         = wait_ms;
    assign o_beat.last_rtt        = n_last_rtt;
    assign o_beat.min_rtt         = n_min_rtt;

endmodule

`default_nettype wire

// ===== rtl/core/heartbeat_link_watchdog_top.sv =====
`default_nettype none

// Heartbeat link watchdog. Each input beat carries one event (round start, pong,
// round end) and yields one result beat, which passes through the input register
// and then the result register; the block takes one beat per cycle while the
// output is not stalled, with the state update between the two registers. Command
// code 3 is accepted and dropped with no result. The result register lets a new
// beat enter while a finished result is stalled; o_in_stall rises only when both
// registers are full and the output is stalled. Configuration (miss threshold at
// byte address 0, backoff cap at byte address 4) is to be written by the user through
// the APB port while the block is idle; the block itself does not enforce this.
module heartbeat_link_watchdog_top import hlw_pkg::*; (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_in_valid,
    output logic                       o_in_stall,
    input  wire t_in_beat              i_in_beat,
    output logic                       o_out_valid,
    input  wire logic                  i_out_stall,
    output t_out_beat                  o_out_beat,
    input  wire logic                  psel,
    input  wire logic                  penable,
    input  wire logic                  pwrite,
    input  wire logic [CFG_ADDR_W-1:0] paddr,
    input  wire logic [CFG_DATA_W-1:0] pwdata,
    output logic      [CFG_DATA_W-1:0] prdata,
    output logic                       pready
);

    t_cfg      cfg;
    t_in_beat  r_in_beat;
    logic      r_in_vld;
    logic      n_in_vld;
    t_out_beat r_out_beat;
    logic      r_out_vld;
    logic      n_out_vld;
    t_out_beat step_beat;
    logic      stage_fire;
    logic      in_accept;
    logic      cmd_ok;

    hlw_cfg_regs u_cfg (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    hlw_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_fire  (stage_fire),
        .i_beat  (r_in_beat),
        .i_cfg   (cfg),
        .o_beat  (step_beat)
    );

    assign stage_fire = r_in_vld && (!r_out_vld || !i_out_stall);
    assign o_in_stall = r_in_vld && !stage_fire;
    assign in_accept  = i_in_valid && !o_in_stall;
    assign cmd_ok     = (i_in_beat.command == CMD_START) || (i_in_beat.command == CMD_PONG)
                        || (i_in_beat.command == CMD_END);

    always_comb begin
        if (in_accept) begin
            n_in_vld = cmd_ok;
        end else if (stage_fire) begin
            n_in_vld = 1'b0;
        end else begin
            n_in_vld = r_in_vld;
        end
        if (stage_fire) begin
            n_out_vld = 1'b1;
        end else if (!i_out_stall) begin
            n_out_vld = 1'b0;
        end else begin
            n_out_vld = r_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_in_vld  <= n_in_vld;
            r_out_vld <= n_out_vld;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_in_beat <= i_in_beat;
        end
        if (stage_fire) begin
            r_out_beat <= step_beat;
        end
    end

    assign o_out_valid = r_out_vld;
    assign o_out_beat  = r_out_beat;

`ifndef SYNTHESIS
    a_fail_is_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.status == ST_FAILED)) |-> o_out_beat.link_down)
        else $error("failed recovery without link down");

    a_wait_only_on_fail: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.status != ST_FAILED)) |-> (o_out_beat.wait_ms == '0))
        else $error("backoff wait reported without failure");

    a_missed_nonzero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_out_beat.status == ST_MISSED)) |-> (o_out_beat.missed_count != '0))
        else $error("missed round with zero miss count");

    a_stall_when_full: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_in_stall |-> (r_in_vld && r_out_vld && i_out_stall))
        else $error("input stalled with room in the pipeline");
`endif

endmodule

`default_nettype wire

// ===== tb/tb_heartbeat_link_watchdog_top.sv =====
`timescale 1ns / 1ps

module tb_heartbeat_link_watchdog_top;
    import hlw_pkg::*;

    localparam int          DIR_ROWS       = 25;
    localparam int          NUM_PHASES     = 7;
    localparam int          NOISE_PCT      = 5;
    localparam int          HOLD_CYCLES    = 400;
    localparam int          WATCHDOG_LIMIT = 3000;
    localparam int          DRAIN_CYCLES   = 4;
    localparam int          RTT_MAX_INT    = 2000000000;
    localparam logic [62:0] MAX63          = {63{1'b1}};
    localparam logic [62:0] RTT_MAX        = 63'd2000000000;
    localparam logic [19:0] BACKOFF_INIT   = 20'd1000;
    localparam logic [7:0]  MISS_CAP       = 8'd255;
    localparam logic [1:0]  CMD_UNUSED     = 2'd3;
    localparam logic        TYPED          = 1'b1;
    localparam logic        PREDICTED      = 1'b0;

    typedef struct packed {
        t_in_beat  beat;
        logic      typed;
        t_out_beat result;
    } t_row;

    logic                  i_clk        = 1'b0;
    logic                  i_rst_n      = 1'b0;
    logic                  i_in_valid   = 1'b0;
    t_in_beat              i_in_beat    = '0;
    logic                  i_out_stall  = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [CFG_ADDR_W-1:0] paddr        = '0;
    logic [CFG_DATA_W-1:0] pwdata       = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    t_out_beat             o_out_beat;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    heartbeat_link_watchdog_top u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_beat   (i_in_beat),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_beat  (o_out_beat),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // watchdog state mirror
    logic        wd_pong_seen       = 1'b0;
    logic [7:0]  wd_miss            = 8'd0;
    logic        wd_down            = 1'b0;
    logic [19:0] wd_backoff         = BACKOFF_INIT;
    logic [31:0] wd_recoveries      = 32'd0;
    logic [30:0] wd_last_rtt        = 31'd0;
    logic [30:0] wd_min_rtt         = 31'd0;
    logic [7:0]  cfg_miss_threshold = MISS_THRESHOLD_RST;
    logic [19:0] cfg_max_backoff    = MAX_BACKOFF_RST;

    t_out_beat   predicted_reports[$];
    t_out_beat   predicted;
    t_out_beat   expected_report;
    logic        has_report;
    logic        row_typed  = 1'b0;
    t_out_beat   row_result = '0;
    int          error_count = 0;
    int          idle_cycles = 0;
    int          send_idle_pct = 0;
    int          stall_pct = 0;
    int          hold_requests = 0;
    int          holds_served = 0;
    int          hold_left = 0;
    int          thr;
    int          cap;

    int phase_thr   [NUM_PHASES] = '{3, 0, 1, 255, 2, 1, -1};
    int phase_cap   [NUM_PHASES] = '{30000, 0, 1000, 1048575, 600000, 1048575, -1};
    int phase_idle  [NUM_PHASES] = '{0, 70, 0, 27, 0, 27, 27};
    int phase_stall [NUM_PHASES] = '{0, 0, 70, 27, 0, 27, 27};
    int phase_items [NUM_PHASES] = '{200, 150, 150, 330, 120, 120, 100};
    int phase_start [NUM_PHASES] = '{20, 20, 20, 1, 20, 15, 20};
    int phase_pong  [NUM_PHASES] = '{25, 25, 25, 1, 25, 3, 25};
    int phase_flag  [NUM_PHASES] = '{30, 30, 30, 30, 20, 3, 30};

    t_row directed_rows [DIR_ROWS] = '{
        {CMD_START, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_STARTED, 1'b0, 8'd0, 32'd0, 20'd0, 31'd0, 31'd0},
        {CMD_END, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_MISSED, 1'b0, 8'd1, 32'd0, 20'd0, 31'd0, 31'd0},
        {CMD_END, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_MISSED, 1'b0, 8'd2, 32'd0, 20'd0, 31'd0, 31'd0},
        {CMD_END, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_FAILED, 1'b1, 8'd0, 32'd1, 20'd1000, 31'd0, 31'd0},
        {CMD_END, MAX63, MAX63, 1'b0, 1'b0, TYPED,
         ST_MISSED, 1'b1, 8'd1, 32'd1, 20'd0, 31'd0, 31'd0},
        {CMD_END, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_MISSED, 1'b1, 8'd2, 32'd1, 20'd0, 31'd0, 31'd0},
        {CMD_END, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_FAILED, 1'b1, 8'd0, 32'd2, 20'd2000, 31'd0, 31'd0},
        {CMD_PONG, MAX63, 63'd0, 1'b0, 1'b0, TYPED,
         ST_PONG_DROPPED, 1'b1, 8'd0, 32'd2, 20'd0, 31'd0, 31'd0},
        {CMD_PONG, 63'd0, MAX63, 1'b0, 1'b0, TYPED,
         ST_PONG_DROPPED, 1'b1, 8'd0, 32'd2, 20'd0, 31'd0, 31'd0},
        {CMD_PONG, 63'd100, 63'd2000000100, 1'b0, 1'b0, TYPED,
         ST_PONG_KEPT, 1'b1, 8'd0, 32'd2, 20'd0, 31'd2000000000, 31'd2000000000},
        {CMD_PONG, 63'd5, 63'd2000000006, 1'b0, 1'b0, TYPED,
         ST_PONG_DROPPED, 1'b1, 8'd0, 32'd2, 20'd0, 31'd2000000000, 31'd2000000000},
        {CMD_PONG, MAX63 - 63'd10, MAX63, 1'b0, 1'b0, TYPED,
         ST_PONG_KEPT, 1'b1, 8'd0, 32'd2, 20'd0, 31'd10, 31'd10},
        {CMD_END, 63'd0, 63'd0, 1'b1, 1'b1, TYPED,
         ST_ANSWERED, 1'b0, 8'd0, 32'd2, 20'd0, 31'd10, 31'd10},
        {CMD_END, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_ANSWERED, 1'b0, 8'd0, 32'd2, 20'd0, 31'd10, 31'd10},
        {CMD_UNUSED, MAX63, MAX63, 1'b1, 1'b1, PREDICTED, 126'd0},
        {CMD_START, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_STARTED, 1'b0, 8'd0, 32'd2, 20'd0, 31'd10, 31'd10},
        {CMD_PONG, 63'd123, 63'd123, 1'b0, 1'b0, TYPED,
         ST_PONG_KEPT, 1'b0, 8'd0, 32'd2, 20'd0, 31'd0, 31'd0},
        {CMD_PONG, 63'd1000, 63'd1050, 1'b0, 1'b0, TYPED,
         ST_PONG_KEPT, 1'b0, 8'd0, 32'd2, 20'd0, 31'd50, 31'd50},
        {CMD_START, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_STARTED, 1'b0, 8'd0, 32'd2, 20'd0, 31'd50, 31'd50},
        {CMD_END, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_MISSED, 1'b0, 8'd1, 32'd2, 20'd0, 31'd50, 31'd50},
        {CMD_END, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_MISSED, 1'b0, 8'd2, 32'd2, 20'd0, 31'd50, 31'd50},
        {CMD_END, 63'd0, 63'd0, 1'b1, 1'b1, TYPED,
         ST_RESET_OK, 1'b0, 8'd0, 32'd3, 20'd0, 31'd50, 31'd50},
        {CMD_END, 63'd0, 63'd0, 1'b0, 1'b0, TYPED,
         ST_MISSED, 1'b0, 8'd1, 32'd3, 20'd0, 31'd50, 31'd50},
        {CMD_END, 63'd0, 63'd0, 1'b0, 1'b0, PREDICTED, 126'd0},
        {CMD_END, 63'd0, 63'd0, 1'b0, 1'b1, TYPED,
         ST_RECONNECT_OK, 1'b0, 8'd0, 32'd4, 20'd0, 31'd50, 31'd50}
    };

    wire in_fire  = i_rst_n && i_in_valid && (o_in_stall === 1'b0);
    wire out_fire = i_rst_n && (o_out_valid === 1'b1) && !i_out_stall;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic logic watchdog_step(input t_in_beat b, output t_out_beat r);
        logic [62:0] rtt;
        logic [31:0] doubled;
        logic [19:0] backoff_wait;
        t_status     st;
        r = '0;
        backoff_wait = '0;
        rtt = b.local_time - b.ping_stamp;
        st = ST_STARTED;
        case (b.command)
            CMD_START: begin
                wd_pong_seen = 1'b0;
                st = ST_STARTED;
            end
            CMD_PONG: begin
                if (b.local_time < b.ping_stamp || rtt > RTT_MAX) begin
                    st = ST_PONG_DROPPED;
                end else begin
                    wd_last_rtt = rtt[30:0];
                    if (wd_min_rtt == 31'd0 || rtt[30:0] < wd_min_rtt)
                        wd_min_rtt = rtt[30:0];
                    wd_pong_seen = 1'b1;
                    st = ST_PONG_KEPT;
                end
            end
            CMD_END: begin
                if (wd_pong_seen) begin
                    wd_miss = 8'd0;
                    wd_backoff = BACKOFF_INIT;
                    wd_down = 1'b0;
                    st = ST_ANSWERED;
                end else begin
                    if (wd_miss != MISS_CAP)
                        wd_miss = wd_miss + 8'd1;
                    if (wd_miss < cfg_miss_threshold) begin
                        st = ST_MISSED;
                    end else begin
                        wd_down = 1'b1;
                        wd_recoveries = wd_recoveries + 32'd1;
                        wd_miss = 8'd0;
                        if (b.reset_ok || b.reconnect_ok) begin
                            wd_down = 1'b0;
                            wd_backoff = BACKOFF_INIT;
                            st = b.reset_ok ? ST_RESET_OK : ST_RECONNECT_OK;
                        end else begin
                            doubled = {12'd0, wd_backoff} << 1;
                            backoff_wait = wd_backoff;
                            wd_backoff = (doubled < {12'd0, cfg_max_backoff}) ?
                                         doubled[19:0] : cfg_max_backoff;
                            st = ST_FAILED;
                        end
                    end
                end
            end
            default: return 1'b0;
        endcase
        r.status = st;
        r.link_down = wd_down;
        r.missed_count = wd_miss;
        r.reconnect_count = wd_recoveries;
        r.wait_ms = backoff_wait;
        r.last_rtt = wd_last_rtt;
        r.min_rtt = wd_min_rtt;
        return 1'b1;
    endfunction

    function automatic t_in_beat gen_beat(input int start_pct, input int pong_pct,
                                          input int flag_pct);
        t_in_beat    b;
        logic [63:0] r_stamp;
        logic [63:0] r_time;
        logic [62:0] rtt;
        int          pick;
        r_stamp = {$urandom(), $urandom()};
        r_time = {$urandom(), $urandom()};
        b.ping_stamp = r_stamp[62:0];
        b.local_time = r_time[62:0];
        b.reset_ok = ($urandom_range(99) < flag_pct);
        b.reconnect_ok = ($urandom_range(99) < flag_pct);
        pick = $urandom_range(99);
        if (pick < NOISE_PCT) begin
            b.command = r_time[63:62];
            b.reset_ok = r_stamp[63];
        end else if (pick < NOISE_PCT + start_pct) begin
            b.command = CMD_START;
        end else if (pick < NOISE_PCT + start_pct + pong_pct) begin
            b.command = CMD_PONG;
            pick = $urandom_range(99);
            if (pick < 10)
                rtt = 63'($urandom_range(3));
            else if (pick < 85)
                rtt = 63'($urandom_range(RTT_MAX_INT));
            else
                rtt = RTT_MAX + 63'($urandom_range(1000000, 1));
            if (pick < 93)
                b.local_time = b.ping_stamp + rtt;
            else
                b.local_time = b.ping_stamp - 63'($urandom_range(1000, 1));
        end else begin
            b.command = CMD_END;
        end
        return b;
    endfunction

    task automatic check_field(input string name, input logic [63:0] want,
                               input logic [63:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        if (in_fire) begin
            has_report = watchdog_step(i_in_beat, predicted);
            if (has_report) begin
                if (row_typed)
                    predicted = row_result;
                predicted_reports.push_back(predicted);
            end
        end
        if (out_fire) begin
            if (predicted_reports.size() == 0) begin
                $error("status: expected no beat, got %0d", o_out_beat.status);
                error_count++;
            end else begin
                expected_report = predicted_reports.pop_front();
                check_field("status", 64'(expected_report.status), 64'(o_out_beat.status));
                check_field("link_down", 64'(expected_report.link_down),
                            64'(o_out_beat.link_down));
                check_field("missed_count", 64'(expected_report.missed_count),
                            64'(o_out_beat.missed_count));
                check_field("reconnect_count", 64'(expected_report.reconnect_count),
                            64'(o_out_beat.reconnect_count));
                check_field("wait_ms", 64'(expected_report.wait_ms),
                            64'(o_out_beat.wait_ms));
                check_field("last_rtt", 64'(expected_report.last_rtt),
                            64'(o_out_beat.last_rtt));
                check_field("min_rtt", 64'(expected_report.min_rtt),
                            64'(o_out_beat.min_rtt));
            end
        end
    end

    // receiver back-pressure, with a single long hold-off
    always @(posedge i_clk) begin
        if (hold_requests != holds_served) begin
            holds_served = hold_requests;
            hold_left = HOLD_CYCLES;
        end
        if (hold_left > 0) begin
            hold_left--;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= ($urandom_range(99) < stall_pct);
        end
    end

    always @(posedge i_clk) begin
        if (in_fire || out_fire)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
        end
    end

    task automatic send_beat(input t_in_beat beat, input logic typed,
                             input t_out_beat result);
        while ($urandom_range(99) < send_idle_pct) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_beat <= beat;
        row_typed <= typed;
        row_result <= result;
        do @(posedge i_clk); while (in_fire !== 1'b1);
    endtask

    task automatic drain_results();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (predicted_reports.size() != 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic apb_transfer(input logic is_write, input t_reg_idx idx,
                                input logic [31:0] wdata, output logic [31:0] rdata);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= is_write;
        paddr <= {idx, 2'b00};
        pwdata <= wdata;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (pready !== 1'b1);
        rdata = prdata;
        psel <= 1'b0;
        penable <= 1'b0;
        @(posedge i_clk);
    endtask

    task automatic configure(input int threshold, input int backoff_cap);
        logic [31:0] rd;
        apb_transfer(1'b1, REG_MISS_THRESHOLD, 32'(threshold), rd);
        apb_transfer(1'b0, REG_MISS_THRESHOLD, 32'd0, rd);
        check_field("miss_threshold", 64'(threshold), 64'(rd));
        apb_transfer(1'b1, REG_MAX_BACKOFF, 32'(backoff_cap), rd);
        apb_transfer(1'b0, REG_MAX_BACKOFF, 32'd0, rd);
        check_field("max_backoff_ms", 64'(backoff_cap), 64'(rd));
        cfg_miss_threshold = 8'(threshold);
        cfg_max_backoff = 20'(backoff_cap);
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        for (int i = 0; i < DIR_ROWS; i++)
            send_beat(directed_rows[i].beat, directed_rows[i].typed,
                      directed_rows[i].result);
        for (int p = 0; p < NUM_PHASES; p++) begin
            drain_results();
            thr = (phase_thr[p] < 0) ? int'($urandom_range(12, 1)) : phase_thr[p];
            cap = (phase_cap[p] < 0) ? int'($urandom_range(20'hFFFFF)) : phase_cap[p];
            configure(thr, cap);
            send_idle_pct = phase_idle[p];
            stall_pct <= phase_stall[p];
            for (int n = 0; n < phase_items[p]; n++) begin
                if (p == 0 && n == 30)
                    hold_requests <= hold_requests + 1;
                if (p == 0 && n == 120)
                    drain_results();
                send_beat(gen_beat(phase_start[p], phase_pong[p], phase_flag[p]),
                          PREDICTED, '0);
            end
        end
        drain_results();
        if (error_count == 0 && predicted_reports.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule
